// ----- rtl/lrgd_pkg.sv -----
// Shared constants for the gradient descent epoch core.
`default_nettype none
package lrgd_pkg;
    localparam int MAX_SAMPLES = 1024;
    localparam int CNT_W       = 11;
    localparam int DIV_W       = 49;
    localparam int DIV_CNT_W   = 6;
    localparam int CFG_IDX_W   = 2;

    localparam logic [CFG_IDX_W-1:0] REG_LEARNING_RATE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_BIAS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_WEIGHT = 2'd2;

    typedef logic [DIV_W-1:0] t_quot;
endpackage
`default_nettype wire

// ----- rtl/lrgd_div.sv -----
// Restoring divider, one quotient bit per cycle, divisor is the sample count.
`default_nettype none
module lrgd_div (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire lrgd_pkg::t_quot           i_dividend,
    input  wire logic [lrgd_pkg::CNT_W-1:0] i_divisor,
    output logic                           o_done,
    output lrgd_pkg::t_quot                o_quotient
);
    logic                               r_busy;
    logic                               r_done;
    logic [lrgd_pkg::DIV_CNT_W-1:0]     r_cnt;
    logic [lrgd_pkg::CNT_W-1:0]         r_rem;
    logic [lrgd_pkg::CNT_W-1:0]         r_dsr;
    lrgd_pkg::t_quot                    r_quo;

    logic [lrgd_pkg::CNT_W:0]           w_sh;
    logic [lrgd_pkg::CNT_W:0]           w_sub;
    logic                               w_ge;

    assign w_sh  = {r_rem, r_quo[lrgd_pkg::DIV_W-1]};
    assign w_ge  = w_sh >= {1'b0, r_dsr};
    assign w_sub = w_sh - {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= lrgd_pkg::DIV_CNT_W'(lrgd_pkg::DIV_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[lrgd_pkg::DIV_W-2:0], w_ge};
            r_rem <= w_ge ? w_sub[lrgd_pkg::CNT_W-1:0] : w_sh[lrgd_pkg::CNT_W-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;
endmodule
`default_nettype wire

// ----- rtl/linear_regression_gd_epoch_core.sv -----
// Gradient descent epoch core for y = w*x + b, top level.
// Input channel (i_in_valid/o_in_ready) takes one sample per transaction:
// x and y in signed Q8.8, a last-sample flag and a restart flag. Restart
// loads the initial bias and weight and clears the sums before the sample.
// o_in_ready is low in S_ERR, S_MUL2, S_ACC1 and S_ACC2 after an accepted
// sample, so a new sample goes in only when the last is through; the shared
// 33x33 multiplier is used three times in sequence per sample.
// A last sample then runs the closing sequence: three divisions by the
// sample count on a one-bit-per-cycle divider (49 steps each) plus the
// multiplies by the learning rate; the result transaction then appears on
// o_out_valid/i_out_ready: mean squared error, new bias, new weight and the
// sample count. The new parameters are stored and the sums cleared when the
// result is loaded into the output register.
// The output register holds one result; while it is not taken the core
// keeps accepting samples and stalls only when a second result is ready.
// Configuration writes (i_cfg_we) take effect at once and must be made idle.
// Synchronous reset clears the parameters, sums, count and handshakes and
// sets the learning rate to 655.
`default_nettype none
module linear_regression_gd_epoch_core (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic signed [15:0]             i_sample_x,
    input  wire logic signed [15:0]             i_sample_y,
    input  wire logic                           i_last_sample,
    input  wire logic                           i_restart,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic [31:0]                         o_mean_squared_error,
    output logic signed [31:0]                  o_new_bias,
    output logic signed [31:0]                  o_new_weight,
    output logic [lrgd_pkg::CNT_W-1:0]          o_samples_used,
    input  wire logic                           i_cfg_we,
    input  wire logic [lrgd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [31:0]                    i_cfg_wdata
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_ERR   = 4'd1;
    localparam logic [3:0] S_MUL2  = 4'd2;
    localparam logic [3:0] S_ACC1  = 4'd3;
    localparam logic [3:0] S_ACC2  = 4'd4;
    localparam logic [3:0] S_MSE   = 4'd5;
    localparam logic [3:0] S_MSEW  = 4'd6;
    localparam logic [3:0] S_MAG   = 4'd7;
    localparam logic [3:0] S_ML    = 4'd8;
    localparam logic [3:0] S_MH    = 4'd9;
    localparam logic [3:0] S_SUM   = 4'd10;
    localparam logic [3:0] S_DIV   = 4'd11;
    localparam logic [3:0] S_DIVW  = 4'd12;
    localparam logic [3:0] S_UPD   = 4'd13;
    localparam logic [3:0] S_OUT   = 4'd14;

    logic [3:0]                    r_state, n_state;
    logic [15:0]                   r_rate;
    logic signed [31:0]            r_init_b, r_init_w;
    logic signed [31:0]            r_bias, r_weight;
    logic signed [47:0]            r_esum, r_exsum;
    logic [47:0]                   r_sqsum;
    logic [lrgd_pkg::CNT_W-1:0]    r_cnt;
    logic signed [15:0]            r_x, r_y;
    logic                          r_last;
    logic signed [31:0]            r_err;
    logic signed [65:0]            r_prod;
    logic [47:0]                   r_mag;
    logic                          r_neg;
    logic                          r_sel;
    logic [39:0]                   r_plo;
    lrgd_pkg::t_quot               r_dvd;
    logic [31:0]                   r_mse;
    logic signed [31:0]            r_nb, r_nw;
    logic                          r_out_valid;
    logic [31:0]                   r_o_mse;
    logic signed [31:0]            r_o_b, r_o_w;
    logic [lrgd_pkg::CNT_W-1:0]    r_o_n;

    logic signed [32:0]            w_mul_a, w_mul_b;
    logic signed [65:0]            w_prod;
    logic                          w_accept;
    logic signed [40:0]            w_pred;
    logic signed [41:0]            w_err_full;
    logic signed [31:0]            w_err;
    logic signed [48:0]            w_esum_n, w_exsum_n;
    logic [48:0]                   w_sq_n;
    logic [63:0]                   w_p;
    logic                          w_div_start;
    logic                          w_div_done;
    lrgd_pkg::t_quot               w_div_in, w_quot;
    logic signed [47:0]            w_sum_sel;
    logic signed [31:0]            w_par_sel;
    logic signed [50:0]            w_delta, w_upd;
    logic signed [31:0]            w_upd_sat;

    function automatic logic signed [47:0] sat48(input logic signed [48:0] v);
        if (v[48] != v[47])
            sat48 = v[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
        else
            sat48 = v[47:0];
    endfunction

    assign w_accept = i_in_valid && o_in_ready;

    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (r_state)
            S_IDLE: begin
                w_mul_a = i_restart ? 33'(r_init_w) : 33'(r_weight);
                w_mul_b = 33'(i_sample_x);
            end
            S_MUL2: begin
                w_mul_a = 33'(r_err);
                w_mul_b = 33'(r_x);
            end
            S_ACC1: begin
                w_mul_a = 33'(r_err);
                w_mul_b = 33'(r_err);
            end
            S_ML: begin
                w_mul_a = {9'd0, r_mag[23:0]};
                w_mul_b = {17'd0, r_rate};
            end
            S_MH: begin
                w_mul_a = {9'd0, r_mag[47:24]};
                w_mul_b = {17'd0, r_rate};
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;

    assign w_pred     = 41'($signed(r_prod[47:8])) + 41'(r_bias);
    assign w_err_full = 42'($signed({r_y, 8'd0})) - 42'(w_pred);
    always_comb begin
        if (w_err_full[41:31] != {11{w_err_full[41]}})
            w_err = w_err_full[41] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        else
            w_err = w_err_full[31:0];
    end

    assign w_esum_n  = 49'(r_esum) + 49'(r_err);
    assign w_exsum_n = 49'(r_exsum) + 49'($signed(r_prod[47:8]));
    assign w_sq_n    = {1'b0, r_sqsum} + {1'b0, r_prod[63:16]};

    assign w_p = {r_prod[39:0], 24'd0} + {24'd0, r_plo};

    assign w_div_start = (r_state == S_MSE) || (r_state == S_DIV);
    assign w_div_in    = (r_state == S_MSE) ? {1'b0, r_sqsum} : r_dvd;

    lrgd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_in),
        .i_divisor  (r_cnt),
        .o_done     (w_div_done),
        .o_quotient (w_quot)
    );

    assign w_sum_sel = r_sel ? r_exsum : r_esum;
    assign w_par_sel = r_sel ? r_weight : r_bias;
    assign w_delta   = r_neg ? -51'({2'b00, w_quot}) : 51'({2'b00, w_quot});
    assign w_upd     = 51'(w_par_sel) + w_delta;
    always_comb begin
        if (w_upd[50:31] != {20{w_upd[50]}})
            w_upd_sat = w_upd[50] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        else
            w_upd_sat = w_upd[31:0];
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (w_accept) n_state = S_ERR;
            S_ERR:   n_state = S_MUL2;
            S_MUL2:  n_state = S_ACC1;
            S_ACC1:  n_state = S_ACC2;
            S_ACC2:  n_state = r_last ? S_MSE : S_IDLE;
            S_MSE:   n_state = S_MSEW;
            S_MSEW:  if (w_div_done) n_state = S_MAG;
            S_MAG:   n_state = S_ML;
            S_ML:    n_state = S_MH;
            S_MH:    n_state = S_SUM;
            S_SUM:   n_state = S_DIV;
            S_DIV:   n_state = S_DIVW;
            S_DIVW:  if (w_div_done) n_state = S_UPD;
            S_UPD:   n_state = r_sel ? S_OUT : S_MAG;
            S_OUT:   if (!r_out_valid || i_out_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rate      <= 16'd655;
            r_init_b    <= '0;
            r_init_w    <= '0;
            r_bias      <= '0;
            r_weight    <= '0;
            r_esum      <= '0;
            r_exsum     <= '0;
            r_sqsum     <= '0;
            r_cnt       <= '0;
            r_sel       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    lrgd_pkg::REG_LEARNING_RATE:  r_rate   <= i_cfg_wdata[15:0];
                    lrgd_pkg::REG_INITIAL_BIAS:   r_init_b <= i_cfg_wdata;
                    lrgd_pkg::REG_INITIAL_WEIGHT: r_init_w <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (r_state == S_OUT && (!r_out_valid || i_out_ready))
                r_out_valid <= 1'b1;
            else if (o_out_valid && i_out_ready)
                r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (w_accept && i_restart) begin
                        r_bias   <= r_init_b;
                        r_weight <= r_init_w;
                        r_esum   <= '0;
                        r_exsum  <= '0;
                        r_sqsum  <= '0;
                        r_cnt    <= '0;
                    end
                end
                S_ACC1: begin
                    r_esum  <= sat48(w_esum_n);
                    r_exsum <= sat48(w_exsum_n);
                end
                S_ACC2: begin
                    r_sqsum <= w_sq_n[48] ? {48{1'b1}} : w_sq_n[47:0];
                    if (r_cnt < lrgd_pkg::CNT_W'(lrgd_pkg::MAX_SAMPLES))
                        r_cnt <= r_cnt + 1'b1;
                    r_sel <= 1'b0;
                end
                S_UPD: r_sel <= 1'b1;
                S_OUT: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_bias      <= r_nb;
                        r_weight    <= r_nw;
                        r_esum      <= '0;
                        r_exsum     <= '0;
                        r_sqsum     <= '0;
                        r_cnt       <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        if (w_accept) begin
            r_x    <= i_sample_x;
            r_y    <= i_sample_y;
            r_last <= i_last_sample;
        end
        if (r_state == S_ERR)
            r_err <= w_err;
        if (r_state == S_MSEW && w_div_done)
            r_mse <= (w_quot[48:32] != '0) ? 32'hFFFF_FFFF : w_quot[31:0];
        if (r_state == S_MAG) begin
            r_neg <= w_sum_sel[47];
            r_mag <= w_sum_sel[47] ? 48'(-w_sum_sel) : 48'(w_sum_sel);
        end
        if (r_state == S_MH)
            r_plo <= r_prod[39:0];
        if (r_state == S_SUM)
            r_dvd <= w_p[63:15];
        if (r_state == S_UPD) begin
            if (r_sel)
                r_nw <= w_upd_sat;
            else
                r_nb <= w_upd_sat;
        end
        if (r_state == S_OUT && (!r_out_valid || i_out_ready)) begin
            r_o_mse <= r_mse;
            r_o_b   <= r_nb;
            r_o_w   <= r_nw;
            r_o_n   <= r_cnt;
        end
    end

    assign o_in_ready           = (r_state == S_IDLE);
    assign o_out_valid          = r_out_valid;
    assign o_mean_squared_error = r_o_mse;
    assign o_new_bias           = r_o_b;
    assign o_new_weight         = r_o_w;
    assign o_samples_used       = r_o_n;
endmodule
`default_nettype wire
